### sv/mpfd_pkg.sv
// shared constants and controller/datapath link types for the frame deframer
package mpfd_pkg;

	localparam int FRAME_SIZE_DEF = 20;
	localparam int PORTS_DEF      = 6;

	localparam int BYTE_W    = 8;
	localparam int PORT_W    = 3;
	localparam int CFG_IDX_W = 3;

	// register map: base ids first, then the local id limit
	localparam int                   BASE_REGS     = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOCAL = 3'd6;

	localparam logic [BYTE_W-1:0] MAX_LOCAL_RST = 8'd15;

	localparam logic [BYTE_W-1:0] HDR0 = 8'hB5;
	localparam logic [BYTE_W-1:0] HDR1 = 8'hA5;
	localparam logic [BYTE_W-1:0] HDR2 = 8'h55;

	localparam int NODE_ID_POS = 6;

	typedef struct packed {
		logic take;    // input transaction this cycle
		logic id_rd;   // read the node id byte
		logic id_cap;  // capture node id, read byte 0
		logic load;    // load output register from memory
		logic next;    // output accepted, read following byte
	} mpfd_cmd_t;

	typedef struct packed {
		logic emit;    // current input completes a frame to send
		logic last;    // stream index sits on the checksum byte
	} mpfd_sts_t;

endpackage

### sv/mpfd_ram.sv
// generic single write port ram with registered read
module mpfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 120
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/mpfd_ctrl.sv
// controller state machine: byte intake and frame streaming sequence
module mpfd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output mpfd_pkg::mpfd_cmd_t cmd,
	input  mpfd_pkg::mpfd_sts_t sts
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ID_RD = 3'd1;
	localparam logic [2:0] S_ID_LD = 3'd2;
	localparam logic [2:0] S_LOAD  = 3'd3;
	localparam logic [2:0] S_SEND  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_SEND);

	assign cmd.take   = in_valid && in_ready;
	assign cmd.id_rd  = (state_q == S_ID_RD);
	assign cmd.id_cap = (state_q == S_ID_LD);
	assign cmd.load   = (state_q == S_LOAD);
	assign cmd.next   = out_valid && out_ready && !sts.last;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.take && sts.emit) begin
					state_d = S_ID_RD;
				end
			end
			S_ID_RD: state_d = S_ID_LD;
			S_ID_LD: state_d = S_LOAD;
			S_LOAD:  state_d = S_SEND;
			S_SEND: begin
				if (out_ready) begin
					state_d = sts.last ? S_IDLE : S_LOAD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/mpfd_dp.sv
// datapath: per-port framers, config registers, frame store and output register
module mpfd_dp #(
	parameter int FRAME_SIZE = mpfd_pkg::FRAME_SIZE_DEF,
	parameter int PORTS      = mpfd_pkg::PORTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mpfd_pkg::mpfd_cmd_t              cmd,
	output mpfd_pkg::mpfd_sts_t              sts,
	input  logic                             cfg_we,
	input  logic [mpfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mpfd_pkg::BYTE_W-1:0]      cfg_data,
	input  logic [mpfd_pkg::PORT_W-1:0]      port,
	input  logic [mpfd_pkg::BYTE_W-1:0]      rx_byte,
	output logic [mpfd_pkg::PORT_W-1:0]      src_port,
	output logic [mpfd_pkg::BYTE_W-1:0]      frame_byte,
	output logic                             last_byte
);

	localparam int CNT_W  = $clog2(FRAME_SIZE + 1);
	localparam int IDX_W  = $clog2(FRAME_SIZE);
	localparam int DEPTH  = PORTS * FRAME_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PSEL_W = (PORTS > 1) ? $clog2(PORTS) : 1;
	localparam int BW     = mpfd_pkg::BYTE_W;

	localparam logic [IDX_W-1:0] IDX_NODE = IDX_W'(mpfd_pkg::NODE_ID_POS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_SIZE - 1);

	// framer state and config
	logic             collecting_q [PORTS];
	logic [CNT_W-1:0] count_q      [PORTS];
	logic [BW-1:0]    xor_q        [PORTS];
	logic [BW-1:0]    base_q       [mpfd_pkg::BASE_REGS];
	logic [BW-1:0]    max_local_q;

	// frame being sent
	logic [ADDR_W-1:0]              off_q;
	logic [BW-1:0]                  base_e_q;
	logic [mpfd_pkg::PORT_W-1:0]    src_port_q;
	logic [IDX_W-1:0]               idx_q;
	logic [BW-1:0]                  local_q;
	logic [BW-1:0]                  mapped_q;
	logic [BW-1:0]                  frame_byte_q;
	logic                           last_q;

	logic              in_range;
	logic [PSEL_W-1:0] p_idx;
	logic              cur_col;
	logic [CNT_W-1:0]  cur_cnt;
	logic [BW-1:0]     cur_x;
	logic [CNT_W-1:0]  n_cnt;
	logic [BW-1:0]     x_new;
	logic [BW-1:0]     base_sel;
	logic              collect_ok;
	logic              start;
	logic              bad_hdr;
	logic              done;
	logic              nxt_col;
	logic [CNT_W-1:0]  nxt_cnt;
	logic [BW-1:0]     nxt_x;
	logic [ADDR_W-1:0] port_off;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [IDX_W-1:0]  rd_idx;
	logic [ADDR_W-1:0] ram_raddr;
	logic [BW-1:0]     ram_rdata;
	logic [BW-1:0]     sum_id;

	assign in_range = ({1'b0, port} < (mpfd_pkg::PORT_W + 1)'(PORTS));
	assign p_idx    = port[PSEL_W-1:0];
	assign cur_col  = collecting_q[p_idx];
	assign cur_cnt  = count_q[p_idx];
	assign cur_x    = xor_q[p_idx];
	assign n_cnt    = cur_cnt + CNT_W'(1);
	assign x_new    = cur_x ^ rx_byte;
	assign base_sel = ({1'b0, port} < (mpfd_pkg::PORT_W + 1)'(mpfd_pkg::BASE_REGS))
		? base_q[port] : '0;

	assign collect_ok = cur_col && (cur_cnt < CNT_W'(FRAME_SIZE));
	// a fresh header byte restarts a framer that is hunting or overfull
	assign start      = !collect_ok && (rx_byte == mpfd_pkg::HDR0);
	assign bad_hdr    = ((n_cnt == CNT_W'(2)) && (rx_byte != mpfd_pkg::HDR1)) ||
		((n_cnt == CNT_W'(3)) && (rx_byte != mpfd_pkg::HDR2));
	assign done       = collect_ok && !bad_hdr && (n_cnt == CNT_W'(FRAME_SIZE));

	assign sts.emit = in_range && done && (x_new == '0) && (base_sel != '0);
	assign sts.last = (idx_q == IDX_LAST);

	always_comb begin
		nxt_col = 1'b0;
		nxt_cnt = '0;
		nxt_x   = '0;
		if (start) begin
			nxt_col = 1'b1;
			nxt_cnt = CNT_W'(1);
			nxt_x   = rx_byte;
		end else if (collect_ok && !bad_hdr && !done) begin
			nxt_col = 1'b1;
			nxt_cnt = n_cnt;
			nxt_x   = x_new;
		end
	end

	assign port_off  = ADDR_W'(p_idx) * ADDR_W'(FRAME_SIZE);
	assign ram_we    = cmd.take && in_range && (start || collect_ok);
	assign ram_waddr = port_off + (start ? '0 : ADDR_W'(cur_cnt));

	always_comb begin
		if (cmd.id_rd) begin
			rd_idx = IDX_NODE;
		end else if (cmd.id_cap) begin
			rd_idx = '0;
		end else if (cmd.next) begin
			rd_idx = idx_q + IDX_W'(1);
		end else begin
			rd_idx = idx_q;
		end
	end

	assign ram_raddr = off_q + ADDR_W'(rd_idx);
	assign sum_id    = ram_rdata + base_e_q;

	mpfd_ram #(
		.WIDTH (BW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rx_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORTS; i++) begin
				collecting_q[i] <= 1'b0;
				count_q[i]      <= '0;
				xor_q[i]        <= '0;
			end
			for (int i = 0; i < mpfd_pkg::BASE_REGS; i++) begin
				base_q[i] <= '0;
			end
			max_local_q <= mpfd_pkg::MAX_LOCAL_RST;
		end else begin
			if (cmd.take && in_range) begin
				collecting_q[p_idx] <= nxt_col;
				count_q[p_idx]      <= nxt_cnt;
				xor_q[p_idx]        <= nxt_x;
			end
			if (cfg_we) begin
				if ({1'b0, cfg_index} < (mpfd_pkg::CFG_IDX_W + 1)'(mpfd_pkg::BASE_REGS)) begin
					base_q[cfg_index] <= cfg_data;
				end else if (cfg_index == mpfd_pkg::CFG_MAX_LOCAL) begin
					max_local_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			off_q      <= port_off;
			base_e_q   <= base_sel;
			src_port_q <= port;
		end
		if (cmd.id_cap) begin
			idx_q    <= '0;
			local_q  <= ram_rdata;
			mapped_q <= (ram_rdata <= max_local_q) ? sum_id : ram_rdata;
		end else if (cmd.next) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.load) begin
			last_q <= (idx_q == IDX_LAST);
			if (idx_q == IDX_NODE) begin
				frame_byte_q <= mapped_q;
			end else if (idx_q == IDX_LAST) begin
				// patch checksum for the rewritten node id
				frame_byte_q <= ram_rdata ^ local_q ^ mapped_q;
			end else begin
				frame_byte_q <= ram_rdata;
			end
		end
	end

	assign src_port   = src_port_q;
	assign frame_byte = frame_byte_q;
	assign last_byte  = last_q;

endmodule

### sv/multi_port_frame_deframer_id_remap.sv
// top level of the multi-port frame deframer with node id remap
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in      | input     | in_valid/in_ready   | port, rx_byte
//  out     | output    | out_valid/out_ready | src_port, frame_byte, last_byte
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// a byte that completes no sendable frame is taken without holding the input
// a byte that completes a frame to send holds the input while the node id is read and captured
// and the frame is streamed: one frame-store read port, registered read, one byte at a time
// reset clears all framers; base ids go to 0 and the local id limit to 15
// out_ready low holds the current output byte and the whole sequence
module multi_port_frame_deframer_id_remap #(
	parameter int FRAME_SIZE = mpfd_pkg::FRAME_SIZE_DEF,
	parameter int PORTS      = mpfd_pkg::PORTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mpfd_pkg::PORT_W-1:0]    port,
	input  logic [mpfd_pkg::BYTE_W-1:0]    rx_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mpfd_pkg::PORT_W-1:0]    src_port,
	output logic [mpfd_pkg::BYTE_W-1:0]    frame_byte,
	output logic                           last_byte,
	input  logic                           cfg_we,
	input  logic [mpfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mpfd_pkg::BYTE_W-1:0]    cfg_data
);

	mpfd_pkg::mpfd_cmd_t cmd;
	mpfd_pkg::mpfd_sts_t sts;

	mpfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mpfd_dp #(
		.FRAME_SIZE (FRAME_SIZE),
		.PORTS      (PORTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.port       (port),
		.rx_byte    (rx_byte),
		.src_port   (src_port),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

### sv/mpfd_checker.sv
// port-level checks for the deframer, bound to the top level
module mpfd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [mpfd_pkg::PORT_W-1:0] src_port,
	input logic [mpfd_pkg::BYTE_W-1:0] frame_byte,
	input logic                        last_byte
);

	// a stalled output transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_byte) &&
		$stable(src_port) && $stable(last_byte))
		else $error("output payload changed while stalled");

	// intake and streaming never overlap
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a frame is streaming");

	// an input transaction cannot produce a byte on the next cycle
	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("output valid right after input transaction");

	// end of frame returns to intake
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_byte |=> !out_valid && in_ready)
		else $error("stream continued after final byte");

	// mid-frame byte is followed by the next byte of the same port
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_byte |=> !out_valid ##1
		(out_valid && $stable(src_port)))
		else $error("frame stream broken mid-frame");

endmodule

bind multi_port_frame_deframer_id_remap mpfd_checker u_mpfd_checker (.*);
